// ===== rtl/timing_wheel_timer_manager_top_macros.svh =====
// Assertion macros for the timer manager RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef TIMING_WHEEL_TIMER_MANAGER_TOP_MACROS_SVH
`define TIMING_WHEEL_TIMER_MANAGER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TWT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWT_ASSERT(label, clk, rst_n, prop, msg)
`define TWT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/twtm_pkg.sv =====
// Shared types and constants of the timer manager.
// Depends on nothing.
package twtm_pkg;
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_ADJUST = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;
    localparam int TIMEOUT_W = 31;
    localparam int ID_W      = 6;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ID_W-1:0]      timer_id;
        logic [TIMEOUT_W-1:0] timeout;
        logic                 periodic;
    } cmd_t;

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] expired_timer;
        logic            last;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ULINK_RD,
        ST_ULINK_WR,
        ST_ULINK_FIX,
        ST_ARM_CALC,
        ST_ARM_RD,
        ST_ARM_WR,
        ST_DONE,
        ST_TICK_RD,
        ST_TICK_HEAD,
        ST_WALK_RD,
        ST_WALK_EVAL,
        ST_WALK_EMIT,
        ST_TICK_END,
        ST_CLEAR
    } state_t;
endpackage

// ===== rtl/twtm_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type given as a parameter.
interface twtm_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/twtm_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module twtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/timing_wheel_timer_manager_top.sv =====
// Top level of the hashed timing wheel timer manager.
// Depends on twtm_pkg, twtm_if, twtm_ram and the macro header.
//
// A hashed timing wheel keeps WHEEL_SLOTS slot heads in one RAM and the
// timer records (links, slot, rotation, timeout, periodic flag) of
// NUM_TIMERS timers in a second RAM plus a flip-flop linked bit per timer.
// Every operation is a short sequence of read-modify-write cycles on those
// RAMs driven by one controller; one transaction is handled at a time.
// Add and adjust first unlink the timer if it is linked and then arm it;
// remove only unlinks it. A tick reads the head of the current slot and
// walks its list one entry at a time: an entry with rotations left loses
// one, an expired one-shot timer is unlinked and an expired periodic timer
// is unlinked and re-armed; each list step waits on the single RAM read
// port. Any stall of the result channel lengthens an operation. Fired
// results are held back one step in a hold register so that the final one
// of a tick can be flagged last, and then go through a one-entry output
// register; the controller waits whenever it must emit a result or end a
// tick while that output register is full and not being read.
// After reset the block runs a clearing pass over the slot head RAM, during
// which no input transaction is accepted.
`include "timing_wheel_timer_manager_top_macros.svh"
module timing_wheel_timer_manager_top
    import twtm_pkg::*;
#(
    parameter int WHEEL_SLOTS = 1024,
    parameter int NUM_TIMERS  = 64
) (
    input  logic clk,
    input  logic rst_n,
    twtm_if.sink   cmd,
    twtm_if.source res
);
    localparam int SW  = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int TW  = $clog2(NUM_TIMERS);
    localparam int LW  = TW + 1;                  // link, NIL at NUM_TIMERS
    localparam int RW  = (TIMEOUT_W > SW) ? TIMEOUT_W - SW + 1 : 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);
    // Entry record: next, prev, slot, rotation, timeout, periodic.
    localparam int EW  = LW + LW + SW + RW + TIMEOUT_W + 1;

    typedef struct packed {
        logic [LW-1:0]        nxt;
        logic [LW-1:0]        prv;
        logic [SW-1:0]        slot;
        logic [RW-1:0]        rot;
        logic [TIMEOUT_W-1:0] tmo;
        logic                 per;
    } entry_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] clr_reg;
    logic [NUM_TIMERS-1:0] linked_reg, linked_next;
    logic [LW-1:0] walk_reg, walk_next;       // current walk entry
    logic [LW-1:0] wnext_reg, wnext_next;     // saved next of walk entry
    logic [TW:0]   steps_reg, steps_next;
    logic          fired_any_reg, fired_any_next;
    logic          in_tick_reg, in_tick_next;
    logic [TW-1:0] tgt_reg, tgt_next;         // entry being unlinked/armed
    entry_t        ent_reg, ent_next;         // working copy of tgt entry
    logic [1:0]    fix_reg, fix_next;         // neighbor fix step
    logic [LW-1:0] head_reg, head_next;

    // Output register.
    logic res_valid_reg;
    res_t res_data_reg;
    logic emit;
    res_t emit_data;

    // RAM ports.
    logic          h_we;
    logic [SW-1:0] h_wa, h_ra;
    logic [LW-1:0] h_wd, h_rd;
    logic          e_we;
    logic [TW-1:0] e_wa, e_ra;
    entry_t        e_wd, e_rd;

    twtm_ram #(.WIDTH(LW), .DEPTH(WHEEL_SLOTS)) u_head (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
    );
    logic [EW-1:0] e_rd_raw;
    twtm_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS)) u_entry (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(EW'(e_wd)), .raddr(e_ra),
        .rdata(e_rd_raw)
    );
    assign e_rd = entry_t'(e_rd_raw);

    // Tick offset and slot arithmetic for arming. The wheel size is a power
    // of two, so the divide and modulo reduce to a shift and a mask; the slot
    // sum then wraps with one compare and subtract.
    logic [TIMEOUT_W-1:0] eff_tmo;
    logic [SW-1:0]        tmo_lo;
    logic [RW-1:0]        tmo_rot;
    logic [SW:0]          slot_sum;
    logic [SW-1:0]        arm_slot;
    assign eff_tmo  = (ent_reg.tmo == '0) ? TIMEOUT_W'(1) : ent_reg.tmo;
    assign tmo_lo   = SW'(eff_tmo % TIMEOUT_W'(WHEEL_SLOTS));
    assign tmo_rot  = RW'(eff_tmo / TIMEOUT_W'(WHEEL_SLOTS));
    assign slot_sum = {1'b0, cur_reg} + {1'b0, tmo_lo};
    assign arm_slot = (slot_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                      SW'(slot_sum - (SW+1)'(WHEEL_SLOTS)) : SW'(slot_sum);

    logic cmd_ok;
    assign cmd_ok = ({1'b0, cmd_reg.timer_id} < (ID_W+1)'(NUM_TIMERS));
    logic out_free;
    assign out_free = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        linked_next    = linked_reg;
        walk_next      = walk_reg;
        wnext_next     = wnext_reg;
        steps_next     = steps_reg;
        fired_any_next = fired_any_reg;
        in_tick_next   = in_tick_reg;
        tgt_next       = tgt_reg;
        ent_next       = ent_reg;
        fix_next       = fix_reg;
        head_next      = head_reg;
        h_we = 1'b0; h_wa = '0; h_wd = NIL; h_ra = '0;
        e_we = 1'b0; e_wa = '0; e_wd = ent_reg; e_ra = tgt_reg;
        emit = 1'b0;
        emit_data = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                h_we = 1'b1; h_wa = clr_reg; h_wd = NIL;
                if (clr_reg == SW'(WHEEL_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.data.kind == KIND_TICK)
                    begin
                        state_next = ST_TICK_RD;
                    end
                    else
                    begin
                        state_next = ST_ULINK_RD;
                    end
                end
            end
            ST_ULINK_RD:
            begin
                in_tick_next = 1'b0;
                tgt_next = TW'(cmd_reg.timer_id);
                e_ra = TW'(cmd_reg.timer_id);
                if (!cmd_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ULINK_WR;
                end
            end
            ST_ULINK_WR:
            begin
                // e_rd holds the entry record of tgt.
                ent_next = e_rd;
                if (!in_tick_reg)
                begin
                    ent_next.tmo = cmd_reg.timeout;
                    ent_next.per = cmd_reg.periodic;
                end
                if (linked_reg[tgt_reg])
                begin
                    linked_next[tgt_reg] = 1'b0;
                    fix_next = 2'd0;
                    state_next = ST_ULINK_FIX;
                    if (e_rd.prv == NIL)
                    begin
                        h_we = 1'b1; h_wa = e_rd.slot; h_wd = e_rd.nxt;
                        fix_next = 2'd1;
                    end
                    e_ra = TW'(e_rd.prv);
                end
                else if (!in_tick_reg && cmd_reg.kind == KIND_REMOVE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ARM_CALC;
                end
            end
            ST_ULINK_FIX:
            begin
                // fix 0: prev record is on e_rd, patch its next.
                // fix 1: issue read of next. fix 2: patch next's prev.
                if (fix_reg == 2'd0)
                begin
                    e_we = 1'b1; e_wa = TW'(ent_reg.prv);
                    e_wd = e_rd; e_wd.nxt = ent_reg.nxt;
                    fix_next = 2'd1;
                end
                else if (fix_reg == 2'd1)
                begin
                    if (ent_reg.nxt == NIL)
                    begin
                        fix_next = 2'd3;
                    end
                    else
                    begin
                        e_ra = TW'(ent_reg.nxt);
                        fix_next = 2'd2;
                    end
                end
                else if (fix_reg == 2'd2)
                begin
                    e_we = 1'b1; e_wa = TW'(ent_reg.nxt);
                    e_wd = e_rd; e_wd.prv = ent_reg.prv;
                    fix_next = 2'd3;
                end
                else
                begin
                    if (in_tick_reg)
                    begin
                        if (ent_reg.per)
                        begin
                            state_next = ST_ARM_CALC;
                        end
                        else
                        begin
                            e_we = 1'b1; e_wa = tgt_reg;
                            state_next = ST_WALK_RD;
                        end
                    end
                    else if (cmd_reg.kind == KIND_REMOVE)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ARM_CALC;
                    end
                end
            end
            ST_ARM_CALC:
            begin
                ent_next.slot = arm_slot;
                ent_next.rot  = tmo_rot;
                h_ra = arm_slot;
                fix_next = 2'd0;
                state_next = ST_ARM_RD;
            end
            ST_ARM_RD:
            begin
                head_next = h_rd;
                ent_next.nxt = h_rd;
                ent_next.prv = NIL;
                if (in_tick_reg && ent_reg.slot == cur_reg && ent_reg.rot != '0)
                begin
                    ent_next.rot = ent_reg.rot - RW'(1);
                end
                e_ra = TW'(h_rd);
                state_next = ST_ARM_WR;
            end
            ST_ARM_WR:
            begin
                // write self, head, then patch old head's prev
                if (fix_reg != 2'd2)
                begin
                    e_we = 1'b1; e_wa = tgt_reg; e_wd = ent_reg;
                    h_we = 1'b1; h_wa = ent_reg.slot; h_wd = LW'(tgt_reg);
                    // Keep the old head record on the read port for the patch.
                    e_ra = TW'(head_reg);
                    linked_next[tgt_reg] = 1'b1;
                    fix_next = 2'd2;
                    if (head_reg == NIL)
                    begin
                        state_next = in_tick_reg ? ST_WALK_RD : ST_DONE;
                    end
                end
                else
                begin
                    e_we = 1'b1; e_wa = TW'(head_reg);
                    e_wd = e_rd; e_wd.prv = LW'(tgt_reg);
                    state_next = in_tick_reg ? ST_WALK_RD : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data = '{fired: 1'b0, expired_timer: '0, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_RD:
            begin
                h_ra = cur_reg;
                in_tick_next = 1'b1;
                fired_any_next = 1'b0;
                steps_next = '0;
                state_next = ST_TICK_HEAD;
            end
            ST_TICK_HEAD:
            begin
                wnext_next = h_rd;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                fix_next = 2'd0;
                if (wnext_reg == NIL || steps_reg == (TW+1)'(NUM_TIMERS))
                begin
                    state_next = ST_TICK_END;
                end
                else
                begin
                    walk_next = wnext_reg;
                    tgt_next = TW'(wnext_reg);
                    e_ra = TW'(wnext_reg);
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_WALK_EVAL;
                end
            end
            ST_WALK_EVAL:
            begin
                wnext_next = e_rd.nxt;
                ent_next = e_rd;
                if (e_rd.rot != '0)
                begin
                    e_we = 1'b1; e_wa = tgt_reg;
                    e_wd = e_rd; e_wd.rot = e_rd.rot - RW'(1);
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_WALK_EMIT;
                end
            end
            ST_WALK_EMIT:
            begin
                // Hold the result one step so the next one can mark last.
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data = '{fired: 1'b1, expired_timer: ID_W'(tgt_reg),
                                  last: 1'b0};
                    fired_any_next = 1'b1;
                    e_ra = tgt_reg;
                    state_next = ST_ULINK_WR;
                end
            end
            ST_TICK_END:
            begin
                if (!fired_any_reg)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        emit_data = '{fired: 1'b0, expired_timer: '0, last: 1'b1};
                        cur_next = (cur_reg == SW'(WHEEL_SLOTS - 1)) ? '0 : cur_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // The held final result must find the output register free.
                    if (out_free)
                    begin
                        cur_next = (cur_reg == SW'(WHEEL_SLOTS - 1)) ? '0 : cur_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fired results are held back one step so the last one can be flagged.
    logic hold_valid_reg;
    res_t hold_reg;
    logic flush;
    assign flush = (state_reg == ST_TICK_END) && fired_any_reg;

    // The output register loads a plain result directly, the held fired
    // result when a newer one arrives, or the held one flagged last at the
    // end of a tick.
    logic out_load;
    res_t out_data;
    always_comb
    begin
        out_load = (emit && (!emit_data.fired || hold_valid_reg)) || (flush && out_free);
        if (emit && !emit_data.fired)
        begin
            out_data = emit_data;
        end
        else if (emit)
        begin
            out_data = hold_reg;
        end
        else
        begin
            out_data = '{fired: hold_reg.fired, expired_timer: hold_reg.expired_timer,
                         last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            cur_reg        <= '0;
            linked_reg     <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            fired_any_reg  <= 1'b0;
            in_tick_reg    <= 1'b0;
            steps_reg      <= '0;
            fix_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_reg + 1'b1;
            cur_reg       <= cur_next;
            linked_reg    <= linked_next;
            fired_any_reg <= fired_any_next;
            in_tick_reg   <= in_tick_next;
            steps_reg     <= steps_next;
            fix_reg       <= fix_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
                res_data_reg  <= out_data;
            end
            else if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (emit && emit_data.fired)
            begin
                hold_valid_reg <= 1'b1;
                hold_reg       <= emit_data;
            end
            else if (flush && out_free)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Command capture on acceptance and the controller's working registers, without reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd.valid)
        begin
            cmd_reg <= cmd.data;
        end
        walk_reg  <= walk_next;
        wnext_reg <= wnext_next;
        tgt_reg   <= tgt_next;
        ent_reg   <= ent_next;
        head_reg  <= head_next;
    end

    `TWT_ASSERT(a_ready_idle, clk, rst_n, cmd.ready |-> !hold_valid_reg,
                "held result pending while idle")
    `TWT_ASSERT(a_no_overwrite, clk, rst_n,
                (res_valid_reg && !res.ready) |=> res_valid_reg,
                "pending result dropped")
    `TWT_ASSERT(a_clear_blocks, clk, rst_n, (state_reg == ST_CLEAR) |-> !cmd.ready,
                "command accepted during clearing pass")
    `TWT_ASSERT(a_steps_bound, clk, rst_n, steps_reg <= (TW+1)'(NUM_TIMERS),
                "walk exceeded timer count")
endmodule

// ===== sim/tb_timing_wheel_timer_manager_top.sv =====
// Self-checking testbench of the hashed timing wheel timer manager.
// Depends on twtm_pkg, twtm_if and timing_wheel_timer_manager_top from the RTL.
`timescale 1ns / 1ps

module tb_timing_wheel_timer_manager_top;
    import twtm_pkg::*;

    localparam int SLOTS       = 1024;
    localparam int TIMERS      = 64;
    localparam int NO_LINK     = TIMERS;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_OPS  = 250;
    // A closing run of ticks so that the short timers left behind come due.
    localparam int TURN_TICKS  = 60;

    // The board keeps its own copy of the wheel. Every accepted command is
    // replayed on that copy, and the results it would give are queued up
    // until the block delivers its own.
    class timer_wheel_board;
        bit [9:0]  cur_slot;
        bit [6:0]  head_of[SLOTS];
        bit        linked[TIMERS];
        bit [6:0]  next_of[TIMERS];
        bit [6:0]  prev_of[TIMERS];
        bit [9:0]  slot_of[TIMERS];
        bit [21:0] turns_left[TIMERS];
        bit [30:0] delay_of[TIMERS];
        bit        repeats[TIMERS];
        res_t      due_results[$];
        int        errors;

        function new();
            cur_slot = '0;
            errors   = 0;
            foreach (head_of[i]) head_of[i] = 7'(NO_LINK);
            foreach (linked[i])
            begin
                linked[i]  = 1'b0;
                next_of[i] = 7'(NO_LINK);
                prev_of[i] = 7'(NO_LINK);
            end
        endfunction

        function void unlink_timer(int t);
            int n;
            int p;
            if (!linked[t])
                return;
            n = next_of[t];
            p = prev_of[t];
            if (p < TIMERS)
                next_of[p] = 7'(n);
            else
                head_of[slot_of[t]] = 7'(n);
            if (n < TIMERS)
                prev_of[n] = 7'(p);
            next_of[t] = 7'(NO_LINK);
            prev_of[t] = 7'(NO_LINK);
            linked[t]  = 1'b0;
        endfunction

        function void arm_timer(int t);
            bit [30:0] ticks;
            bit [9:0]  s;
            ticks = (delay_of[t] == 0) ? 31'd1 : delay_of[t];
            turns_left[t] = 22'(ticks[30:10]);
            s = cur_slot + ticks[9:0];
            slot_of[t] = s;
            next_of[t] = head_of[s];
            prev_of[t] = 7'(NO_LINK);
            if (head_of[s] < TIMERS)
                prev_of[head_of[s]] = 7'(t);
            head_of[s] = 7'(t);
            linked[t]  = 1'b1;
        endfunction

        function void push_result(bit fired, bit [ID_W-1:0] id, bit last);
            res_t r;
            r.fired         = fired;
            r.expired_timer = id;
            r.last          = last;
            due_results.push_back(r);
        endfunction

        function void note_command(cmd_t c);
            int   t;
            int   nxt;
            int   steps;
            int   fired_count;
            res_t r;
            if (c.kind != KIND_TICK)
            begin
                t = c.timer_id;
                unlink_timer(t);
                // Add of a linked timer and adjust of an unlinked one both
                // end up as a plain re-arm.
                if (c.kind != KIND_REMOVE)
                begin
                    delay_of[t] = c.timeout;
                    repeats[t]  = c.periodic;
                    arm_timer(t);
                end
                push_result(1'b0, '0, 1'b1);
                return;
            end
            t = head_of[cur_slot];
            steps = 0;
            fired_count = 0;
            while (t < TIMERS && steps < TIMERS)
            begin
                nxt = next_of[t];
                steps++;
                if (turns_left[t] > 0)
                    turns_left[t]--;
                else
                begin
                    push_result(1'b1, ID_W'(t), 1'b0);
                    fired_count++;
                    unlink_timer(t);
                    if (repeats[t])
                    begin
                        arm_timer(t);
                        // Landing back in this slot would otherwise cost one
                        // extra turn, since the walk is already past it.
                        if (slot_of[t] == cur_slot && turns_left[t] > 0)
                            turns_left[t]--;
                    end
                end
                t = nxt;
            end
            cur_slot = cur_slot + 1'b1;
            if (fired_count == 0)
                push_result(1'b0, '0, 1'b1);
            else
            begin
                r = due_results.pop_back();
                r.last = 1'b1;
                due_results.push_back(r);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                $error("unexpected result fired=%0d timer=%0d last=%0d",
                       got.fired, got.expired_timer, got.last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.fired !== want.fired)
            begin
                $error("fired: expected %0d, actual %0d", want.fired, got.fired);
                errors++;
            end
            if (got.expired_timer !== want.expired_timer)
            begin
                $error("expired_timer: expected %0d, actual %0d",
                       want.expired_timer, got.expired_timer);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   cmd_burst;
    bit   res_burst;

    timer_wheel_board board;

    twtm_if #(.payload_t(cmd_t)) cmd_ch (clk);
    twtm_if #(.payload_t(res_t)) res_ch (clk);

    timing_wheel_timer_manager_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Free-running 12 ns clock.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Each side sometimes runs in bursts with no gaps at all, and otherwise
    // draws a random gap before each transaction.
    function automatic int gap_cycles(bit burst);
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    // Issues one command transaction. Valid is only lowered when a gap
    // follows, so back-to-back commands never see two updates of valid
    // in the same time step.
    task automatic send_command(logic [1:0] kind, int id, bit [30:0] timeout, bit periodic);
        cmd_t c;
        int   gap;
        c.kind     = kind;
        c.timer_id = ID_W'(id);
        c.timeout  = timeout;
        c.periodic = periodic;
        if ($urandom_range(0, 39) == 0)
            cmd_burst = !cmd_burst;
        gap = gap_cycles(cmd_burst);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        board.note_command(c);
    endtask

    // Timeouts cover immediate ones, small delays, whole wheel turns and
    // the full 31-bit range.
    function automatic bit [30:0] pick_timeout();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return 31'($urandom_range(0, 12));
        else if (sel < 85)
            return 31'(SLOTS * $urandom_range(1, 3) + $urandom_range(0, 3));
        else
            return 31'($urandom & 32'h7FFF_FFFF);
    endfunction

    // Mostly a small set of timers so that they are re-added, adjusted and
    // removed while still linked; now and then any index.
    function automatic int pick_timer();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, TIMERS - 1)
                                           : $urandom_range(0, 15);
    endfunction

    // Result side: ready drops for a random number of cycles between
    // transactions, and each accepted result goes straight to the board.
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                res_burst = !res_burst;
            gap = gap_cycles(res_burst);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            board.check_result(res_ch.data);
        end
    end

    // Watchdog on the whole run, including the clearing pass after reset.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_timing_wheel_timer_manager_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int sel;
        board        = new();
        cycle_count  = 0;
        cmd_burst    = 1'b0;
        res_burst    = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A zero timeout acts as one tick, the largest timeout
        // never comes due, a periodic one-tick timer fires on every tick,
        // timer 2 is added again while linked, timer 3 is adjusted before it
        // was ever armed, and timer 4 is removed while not linked.
        send_command(KIND_ADD, 0, 31'd0, 1'b0);
        send_command(KIND_ADD, 1, 31'd1, 1'b1);
        send_command(KIND_ADD, 63, 31'h7FFF_FFFF, 1'b0);
        send_command(KIND_ADD, 2, 31'd5, 1'b0);
        send_command(KIND_ADD, 2, 31'd2, 1'b1);
        send_command(KIND_ADJUST, 3, 31'd3, 1'b0);
        send_command(KIND_REMOVE, 4, 31'd0, 1'b0);
        send_command(KIND_ADD, 5, 31'd2, 1'b0);
        send_command(KIND_ADD, 6, 31'd2, 1'b0);
        repeat (5) send_command(KIND_TICK, 0, 31'd0, 1'b0);
        send_command(KIND_REMOVE, 1, 31'd0, 1'b0);
        send_command(KIND_REMOVE, 2, 31'd0, 1'b0);
        // Whole-turn periodic timers land back in the slot they fire from.
        send_command(KIND_ADJUST, 7, 31'(SLOTS), 1'b1);
        send_command(KIND_ADD, 8, 31'(2 * SLOTS), 1'b1);
        send_command(KIND_ADD, 9, 31'h5555_5555, 1'b1);
        send_command(KIND_TICK, 0, 31'd0, 1'b0);
        send_command(KIND_REMOVE, 9, 31'd0, 1'b0);

        // Random mix weighted toward ticks so that many timers come due.
        repeat (RANDOM_OPS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_command(KIND_TICK, $urandom_range(0, TIMERS - 1), pick_timeout(),
                             1'($urandom_range(0, 1)));
            else if (sel < 75)
                send_command(KIND_ADD, pick_timer(), pick_timeout(),
                             1'($urandom_range(0, 1)));
            else if (sel < 85)
                send_command(KIND_ADJUST, pick_timer(), pick_timeout(),
                             1'($urandom_range(0, 1)));
            else
                send_command(KIND_REMOVE, pick_timer(), pick_timeout(),
                             1'($urandom_range(0, 1)));
        end

        // A closing run of ticks with a few short timers sprinkled in.
        for (int i = 0; i < TURN_TICKS; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_command(KIND_ADD, pick_timer(), 31'($urandom_range(0, 12)),
                             1'($urandom_range(0, 1)));
            send_command(KIND_TICK, 0, 31'd0, 1'b0);
        end

        cmd_ch.valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (board.errors == 0)
            $display("tb_timing_wheel_timer_manager_top OK");
        else
            $display("tb_timing_wheel_timer_manager_top NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/twtm_pkg.sv
rtl/twtm_if.sv
rtl/twtm_ram.sv
rtl/timing_wheel_timer_manager_top.sv
sim/tb_timing_wheel_timer_manager_top.sv
